// ===== sv/blp_pkg.sv =====
// Shared constants and types for the BMP to LCD page packer.
package blp_pkg;

    localparam int PANEL_WIDTH  = 120;
    localparam int PANEL_HEIGHT = 64;

    localparam int LANES      = 8;
    localparam int LANE_W     = $clog2(LANES);
    localparam int BANK_DEPTH = (PANEL_WIDTH + LANES - 1) / LANES;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    localparam int DATA_W     = 8;
    localparam int PAGE_W     = 3;
    localparam int COL_W      = 7;
    localparam int ROWPOS_W   = 10;
    localparam int XPOS_W     = ROWPOS_W + LANE_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int Y_W        = CFG_DATA_W + 1;

    localparam logic [CFG_DATA_W-1:0] HEIGHT_MAX = 11'd1024;
    localparam logic [ROWPOS_W-1:0]   ROW_MAX    = 10'd1023;
    localparam logic [3:0]            NIB_MASK   = 4'hF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd2;

    // Per-byte control broadcast to every lane
    typedef struct packed {
        logic                we;
        logic                four_bit;
        logic [ROWPOS_W-1:0] byte_in_row;
        logic [PAGE_W-1:0]   sub;
        logic [DATA_W-1:0]   data;
    } t_lane_ctl;

    // What one lane found for the current byte
    typedef struct packed {
        logic              hit;
        logic              last_col;
        logic [COL_W-1:0]  col;
        logic [DATA_W-1:0] bits;
    } t_lane_res;

endpackage

// ===== sv/blp_lane.sv =====
// One pixel lane: decodes its pixel and holds the column bank for columns x % LANES == lane.
module blp_lane (
    input  logic                     i_clk,
    input  logic [blp_pkg::LANE_W-1:0] i_lane,
    input  blp_pkg::t_lane_ctl       i_ctl,
    output blp_pkg::t_lane_res       o_res
);
    import blp_pkg::*;

    logic [DATA_W-2:0] r_bank [BANK_DEPTH];

    logic [ROWPOS_W-1:0] q;
    logic [XPOS_W-1:0]   x;
    logic                active;
    logic                lit;
    logic                hit;
    logic [BANK_AW-1:0]  addr;
    logic [PAGE_W-1:0]   bit_sel;

    always_comb begin
        if (i_ctl.four_bit) begin
            // 2 pixels per byte: lanes 2r and 2r+1 take byte r of each group of 4
            q      = i_ctl.byte_in_row >> 2;
            active = (i_lane[LANE_W-1:1] == i_ctl.byte_in_row[1:0]);
            lit    = i_lane[0] ? ((i_ctl.data[3:0] & NIB_MASK) != 4'd0)
                               : ((i_ctl.data[7:4] & NIB_MASK) != 4'd0);
        end else begin
            q      = i_ctl.byte_in_row;
            active = 1'b1;
            lit    = i_ctl.data[DATA_W-1-int'(i_lane)];
        end
        x       = {q, {LANE_W{1'b0}}} | {{ROWPOS_W{1'b0}}, i_lane};
        hit     = active && (x < XPOS_W'(PANEL_WIDTH));
        addr    = q[BANK_AW-1:0];
        bit_sel = i_ctl.sub - 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.we && hit) begin
            r_bank[addr][bit_sel] <= lit;
        end
    end

    always_comb begin
        o_res.hit      = hit;
        o_res.last_col = (x == XPOS_W'(PANEL_WIDTH - 1));
        o_res.col      = x[COL_W-1:0];
        o_res.bits     = {r_bank[addr], lit};
    end

endmodule

// ===== sv/blp_merge.sv =====
// Result buffer: captures what the lanes found for one byte and sends it out in column order.
module blp_merge (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  logic [blp_pkg::PAGE_W-1:0] i_page,
    input  blp_pkg::t_lane_res      i_res [blp_pkg::LANES],
    output logic                    o_free,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [blp_pkg::PAGE_W-1:0] o_page_index,
    output logic [blp_pkg::COL_W-1:0]  o_column_index,
    output logic [blp_pkg::DATA_W-1:0] o_page_byte,
    output logic                    o_end_of_run,
    output logic                    o_end_of_frame
);
    import blp_pkg::*;

    logic [LANES-1:0]  r_mask, n_mask;
    logic [PAGE_W-1:0] r_page;
    logic [COL_W-1:0]  r_col  [LANES];
    logic [DATA_W-1:0] r_bits [LANES];
    logic [LANES-1:0]  r_last;

    logic [LANE_W-1:0] sel;
    logic [LANES-1:0]  rest;
    logic [LANES-1:0]  hits;

    always_comb begin
        sel = '0;
        for (int k = LANES - 1; k >= 0; k--) begin
            if (r_mask[k]) sel = LANE_W'(k);
        end
        rest = r_mask & ~(LANES'(1) << sel);
        for (int k = 0; k < LANES; k++) begin
            hits[k] = i_res[k].hit;
        end
    end

    assign o_valid        = |r_mask;
    assign o_free         = (r_mask == '0) || ((rest == '0) && i_ready);
    assign o_page_index   = r_page;
    assign o_column_index = r_col[sel];
    assign o_page_byte    = r_bits[sel];
    assign o_end_of_run   = (rest == '0);
    assign o_end_of_frame = (r_page == '0) && r_last[sel];

    always_comb begin
        n_mask = r_mask;
        if (o_valid && i_ready) n_mask = rest;
        if (i_load) n_mask = hits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_page <= i_page;
            for (int k = 0; k < LANES; k++) begin
                r_col[k]  <= i_res[k].col;
                r_bits[k] <= i_res[k].bits;
                r_last[k] <= i_res[k].last_col;
            end
        end
    end

endmodule

// ===== sv/bmp_to_lcd_page_packer_top.sv =====
// Top level of the BMP to LCD page packer: configuration, row counters, lanes and result buffer.
//
//  channel   signals                                      dir
//  in        i_valid/o_ready, i_data_byte, i_frame_start  in
//  out       o_valid/i_ready, o_page_index, o_column_index,
//            o_page_byte, o_end_of_run, o_end_of_frame    out
//  cfg       i_cfg_we, i_cfg_index, i_cfg_data            in
//
// Eight lanes handle all pixels of a byte in the transfer cycle, so a byte that only
// updates the column banks is written straight into them. A byte on a page's top row
// loads up to 8 results (2 in 4-bit mode) into the result buffer, drained one per cycle
// while i_ready is high; the next byte is taken in the cycle the last of them transfers.
// Synchronous reset restores counters, config and buffer state; the column banks are not cleared.
module bmp_to_lcd_page_packer_top
    import blp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [DATA_W-1:0]     i_data_byte,
    input  logic                  i_frame_start,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [PAGE_W-1:0]     o_page_index,
    output logic [COL_W-1:0]      o_column_index,
    output logic [DATA_W-1:0]     o_page_byte,
    output logic                  o_end_of_run,
    output logic                  o_end_of_frame,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic                  r_four_bit;
    logic [CFG_DATA_W-1:0] r_width;
    logic [CFG_DATA_W-1:0] r_height;

    logic [ROWPOS_W-1:0]   r_byte_in_row, n_byte_in_row;
    logic [ROWPOS_W-1:0]   r_file_row, n_file_row;
    logic                  r_frame_done, n_frame_done;

    logic                  accept;
    logic                  free;
    logic [ROWPOS_W-1:0]   bir;
    logic [ROWPOS_W-1:0]   frow;
    logic                  fdone;
    logic [13:0]           row_bits;
    logic [13:0]           row_sum;
    logic [CFG_DATA_W-1:0] row_len;
    logic [CFG_DATA_W-1:0] h_eff;
    logic [Y_W-1:0]        y;
    logic                  in_win;
    logic                  y_le0;
    logic                  live;
    t_lane_ctl             ctl;
    t_lane_res             res [LANES];

    assign o_ready = free;
    assign accept  = i_valid && free;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_four_bit <= 1'b0;
            r_width    <= CFG_DATA_W'(PANEL_WIDTH);
            r_height   <= CFG_DATA_W'(PANEL_HEIGHT);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FOUR_BIT: r_four_bit <= i_cfg_data[0];
                CFG_WIDTH:    r_width    <= i_cfg_data;
                CFG_HEIGHT:   r_height   <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    always_comb begin
        // frame_start clears the counters before the byte is used
        bir   = i_frame_start ? '0 : r_byte_in_row;
        frow  = i_frame_start ? '0 : r_file_row;
        fdone = i_frame_start ? 1'b0 : r_frame_done;

        // padded row length in bytes: ceil(width * bpp / 32) * 4
        row_bits = r_four_bit ? {1'b0, r_width, 2'b00} : {3'b000, r_width};
        row_sum  = row_bits + 14'd31;
        row_len  = {row_sum[13:5], 2'b00};
        if (row_len == '0) row_len = CFG_DATA_W'(4);

        h_eff  = (r_height > HEIGHT_MAX) ? HEIGHT_MAX : r_height;
        y      = {1'b0, h_eff} - Y_W'(1) - {2'b00, frow};
        in_win = !y[Y_W-1] && (y < Y_W'(PANEL_HEIGHT));
        y_le0  = y[Y_W-1] || (y == '0);
        live   = accept && !fdone;

        n_byte_in_row = r_byte_in_row;
        n_file_row    = r_file_row;
        n_frame_done  = r_frame_done;
        if (accept) begin
            n_byte_in_row = bir;
            n_file_row    = frow;
            n_frame_done  = fdone;
            if (!fdone) begin
                if ({1'b0, bir} + CFG_DATA_W'(1) >= row_len) begin
                    n_byte_in_row = '0;
                    if (y_le0) begin
                        n_frame_done = 1'b1;
                    end else if (frow < ROW_MAX) begin
                        n_file_row = frow + ROWPOS_W'(1);
                    end
                end else begin
                    n_byte_in_row = bir + ROWPOS_W'(1);
                end
            end
        end

        ctl.we          = live && in_win && (y[2:0] != 3'd0);
        ctl.four_bit    = r_four_bit;
        ctl.byte_in_row = bir;
        ctl.sub         = y[2:0];
        ctl.data        = i_data_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_in_row <= '0;
            r_file_row    <= '0;
            r_frame_done  <= 1'b0;
        end else begin
            r_byte_in_row <= n_byte_in_row;
            r_file_row    <= n_file_row;
            r_frame_done  <= n_frame_done;
        end
    end

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        blp_lane u_lane (
            .i_clk  (i_clk),
            .i_lane (LANE_W'(k)),
            .i_ctl  (ctl),
            .o_res  (res[k])
        );
    end

    blp_merge u_merge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (live && in_win && (y[2:0] == 3'd0)),
        .i_page         (y[5:3]),
        .i_res          (res),
        .o_free         (free),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_page_index   (o_page_index),
        .o_column_index (o_column_index),
        .o_page_byte    (o_page_byte),
        .o_end_of_run   (o_end_of_run),
        .o_end_of_frame (o_end_of_frame)
    );

endmodule
